### src/clqc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the capture level quality check
package clqc_pkg;

    localparam int SAMPLE_W      = 24;
    localparam int SQ_W          = 2 * SAMPLE_W;
    localparam int CNT_W         = 21;
    localparam int RATIO_W       = 32;
    localparam int RATIO_FRAC    = 8;
    localparam int SUM_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int MAX_SAMPLES   = 1048576;
    localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int MUL_W         = 32;
    localparam int RM_W          = RATIO_W + CNT_W;
    localparam int ACC_W         = 119;
    localparam int MUL_STEPS     = 7;
    localparam int STEP_W        = 3;

    localparam logic [CNT_W-1:0] COUNT_CAP =
        CNT_W'((MAX_SAMPLES < CNT_FIELD_MAX) ? MAX_SAMPLES : CNT_FIELD_MAX);
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << RATIO_FRAC);

    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_FLOOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD_PEAK_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SNR_RATIO_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_COUNT      = 3'd4;

    localparam logic [SAMPLE_W-1:0] RST_CLIP_THRESHOLD = 24'd8388000;
    localparam logic [SAMPLE_W-1:0] RST_SILENCE_FLOOR  = 24'd8388;
    localparam logic [SAMPLE_W-1:0] RST_GOOD_PEAK_MIN  = 24'd838861;
    localparam logic [RATIO_W-1:0]  RST_SNR_RATIO_MIN  = 32'd256000;
    localparam logic [CNT_W-1:0]    RST_PRE_COUNT      = 21'd4800;

    typedef struct packed {
        logic [SAMPLE_W-1:0] clip_threshold;
        logic [SAMPLE_W-1:0] silence_floor;
        logic [SAMPLE_W-1:0] good_peak_min;
        logic [RATIO_W-1:0]  snr_ratio_min;
        logic [CNT_W-1:0]    pre_count;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] peak;
        logic [CNT_W-1:0]    clip;
        logic [CNT_W-1:0]    total;
        logic [SUM_W-1:0]    noise_sum;
        logic [SUM_W-1:0]    signal_sum;
    } t_summary;

    typedef enum logic [2:0] {
        Q_OK        = 3'd0,
        Q_SILENT    = 3'd1,
        Q_CLIPPING  = 3'd2,
        Q_LEVEL_LOW = 3'd3,
        Q_LOW_SNR   = 3'd4
    } t_quality;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_DRAIN,
        B_DONE
    } t_back_state;

endpackage

### src/clqc_front.sv
`timescale 1ns / 1ps
// sample front end: magnitude, peak, counters, squaring and power sums
module clqc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  clqc_pkg::t_cfg                       i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [clqc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_last,
    output logic                                 o_push,
    input  logic                                 i_push_ready,
    output clqc_pkg::t_summary                   o_summary
);
    import clqc_pkg::*;

    logic [SAMPLE_W-1:0] r_peak;
    logic [CNT_W-1:0]    r_clip;
    logic [CNT_W-1:0]    r_cnt;
    logic [SUM_W-1:0]    r_noise_sum;
    logic [SUM_W-1:0]    r_signal_sum;

    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_mag;
    logic                r_s1_noise;
    logic                r_s1_last;
    logic [SAMPLE_W-1:0] r_s1_peak;
    logic [CNT_W-1:0]    r_s1_clip;
    logic [CNT_W-1:0]    r_s1_cnt;

    logic                r_s2_valid;
    logic [SQ_W-1:0]     r_s2_sq;
    logic                r_s2_noise;
    logic                r_s2_last;
    logic [SAMPLE_W-1:0] r_s2_peak;
    logic [CNT_W-1:0]    r_s2_clip;
    logic [CNT_W-1:0]    r_s2_cnt;

    logic                w_adv;
    logic                w_accept;
    logic [SAMPLE_W-1:0] w_mag;
    logic                w_is_noise;
    logic [SAMPLE_W-1:0] n_peak;
    logic [CNT_W-1:0]    n_clip;
    logic [CNT_W-1:0]    n_cnt;
    logic [SUM_W:0]      w_noise_add;
    logic [SUM_W:0]      w_signal_add;
    logic [SUM_W-1:0]    n_noise_sum;
    logic [SUM_W-1:0]    n_signal_sum;

    assign w_adv    = !(r_s2_valid && r_s2_last && !i_push_ready);
    assign o_ready  = w_adv;
    assign w_accept = i_valid && w_adv;

    // two's complement magnitude, full scale negative maps to 2^23
    assign w_mag = i_sample[SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;

    always_comb begin
        n_peak     = (w_mag > r_peak) ? w_mag : r_peak;
        n_clip     = (w_mag >= i_cfg.clip_threshold && r_clip < COUNT_CAP) ?
                     r_clip + 1'b1 : r_clip;
        n_cnt      = (r_cnt < COUNT_CAP) ? r_cnt + 1'b1 : r_cnt;
        w_is_noise = r_cnt < i_cfg.pre_count;

        w_noise_add  = {1'b0, r_noise_sum} + (SUM_W+1)'(r_s2_sq);
        w_signal_add = {1'b0, r_signal_sum} + (SUM_W+1)'(r_s2_sq);
        n_noise_sum  = r_noise_sum;
        n_signal_sum = r_signal_sum;
        if (r_s2_valid && r_s2_noise) begin
            n_noise_sum = w_noise_add[SUM_W] ? '1 : w_noise_add[SUM_W-1:0];
        end
        if (r_s2_valid && !r_s2_noise) begin
            n_signal_sum = w_signal_add[SUM_W] ? '1 : w_signal_add[SUM_W-1:0];
        end
    end

    assign o_push               = r_s2_valid && r_s2_last;
    assign o_summary.peak       = r_s2_peak;
    assign o_summary.clip       = r_s2_clip;
    assign o_summary.total      = r_s2_cnt;
    assign o_summary.noise_sum  = n_noise_sum;
    assign o_summary.signal_sum = n_signal_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak       <= '0;
            r_clip       <= '0;
            r_cnt        <= '0;
            r_noise_sum  <= '0;
            r_signal_sum <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
        end else if (w_adv) begin
            if (w_accept) begin
                if (i_last) begin
                    r_peak <= '0;
                    r_clip <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_peak <= n_peak;
                    r_clip <= n_clip;
                    r_cnt  <= n_cnt;
                end
            end
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                if (r_s2_last) begin
                    r_noise_sum  <= '0;
                    r_signal_sum <= '0;
                end else begin
                    r_noise_sum  <= n_noise_sum;
                    r_signal_sum <= n_signal_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_mag   <= w_mag;
            r_s1_noise <= w_is_noise;
            r_s1_last  <= i_last;
            r_s1_peak  <= n_peak;
            r_s1_clip  <= n_clip;
            r_s1_cnt   <= n_cnt;
            r_s2_sq    <= r_s1_mag * r_s1_mag;
            r_s2_noise <= r_s1_noise;
            r_s2_last  <= r_s1_last;
            r_s2_peak  <= r_s1_peak;
            r_s2_clip  <= r_s1_clip;
            r_s2_cnt   <= r_s1_cnt;
        end
    end

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> (r_cnt == '0 && r_clip == '0 && r_peak == '0))
        else $error("running state not cleared after last word");

    a_clip_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clip <= r_cnt)
        else $error("clip count exceeds sample count");

endmodule

### src/clqc_queue.sv
`timescale 1ns / 1ps
// small fifo of capture summaries between front and back
module clqc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_ready,
    input  clqc_pkg::t_summary i_data,
    output logic               o_valid,
    input  logic               i_pop,
    output clqc_pkg::t_summary o_data
);
    import clqc_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(QUEUE_DEPTH);

    t_summary          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_ready = r_count != FULL_CNT;
    assign o_valid = r_count != '0;
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("summary queue fill beyond depth");

endmodule

### src/clqc_back.sv
`timescale 1ns / 1ps
// back end: snr cross-multiply on a shared 32x32 multiplier and quality decision
module clqc_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  clqc_pkg::t_cfg                   i_cfg,
    input  logic                             i_rec_valid,
    output logic                             o_pop,
    input  clqc_pkg::t_summary               i_rec,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [clqc_pkg::SAMPLE_W-1:0]    o_peak_level,
    output logic [clqc_pkg::CNT_W-1:0]       o_clipped_count,
    output clqc_pkg::t_quality               o_quality,
    output logic [clqc_pkg::CNT_W-1:0]       o_sample_total
);
    import clqc_pkg::*;

    // multiplier schedule: ratio*m first, then signal*n*256, then noise*ratio*m
    localparam logic [STEP_W-1:0] STEP_RM     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SIG_LO = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SIG_HI = 3'd2;
    localparam logic [STEP_W-1:0] STEP_NZ_LL  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_NZ_LH  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_NZ_HL  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_NZ_HH  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_END    = STEP_W'(MUL_STEPS - 1);

    t_back_state         r_state;
    t_back_state         n_state;
    logic [STEP_W-1:0]   r_step;
    t_summary            r_rec;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_m;
    logic                r_zero;
    logic [RM_W-1:0]     r_rm;
    logic [2*MUL_W-1:0]  r_prod;
    logic [STEP_W-1:0]   r_prod_step;
    logic                r_prod_valid;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_peak;
    logic [CNT_W-1:0]    r_out_clip;
    t_quality            r_out_quality;
    logic [CNT_W-1:0]    r_out_total;

    logic                w_load_out;
    logic [CNT_W-1:0]    w_n;
    logic [CNT_W-1:0]    w_m;
    logic [MUL_W-1:0]    w_a;
    logic [MUL_W-1:0]    w_b;
    logic [MUL_W-1:0]    w_n8;
    logic [ACC_W-1:0]    w_term;
    logic                w_snr_low;
    t_quality            w_quality;

    assign w_n  = (i_cfg.pre_count < i_rec.total) ? i_cfg.pre_count : i_rec.total;
    assign w_m  = i_rec.total - w_n;
    assign w_n8 = MUL_W'({r_n, {RATIO_FRAC{1'b0}}});

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_rec_valid) begin
                    o_pop   = 1'b1;
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                if (r_step == STEP_END) begin
                    n_state = B_DRAIN;
                end
            end
            B_DRAIN: begin
                n_state = B_DONE;
            end
            B_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        case (r_step)
            STEP_RM: begin
                w_a = i_cfg.snr_ratio_min;
                w_b = MUL_W'(r_m);
            end
            STEP_SIG_LO: begin
                w_a = r_rec.signal_sum[MUL_W-1:0];
                w_b = w_n8;
            end
            STEP_SIG_HI: begin
                w_a = r_rec.signal_sum[SUM_W-1:MUL_W];
                w_b = w_n8;
            end
            STEP_NZ_LL: begin
                w_a = r_rec.noise_sum[MUL_W-1:0];
                w_b = r_rm[MUL_W-1:0];
            end
            STEP_NZ_LH: begin
                w_a = r_rec.noise_sum[MUL_W-1:0];
                w_b = MUL_W'(r_rm[RM_W-1:MUL_W]);
            end
            STEP_NZ_HL: begin
                w_a = r_rec.noise_sum[SUM_W-1:MUL_W];
                w_b = r_rm[MUL_W-1:0];
            end
            STEP_NZ_HH: begin
                w_a = r_rec.noise_sum[SUM_W-1:MUL_W];
                w_b = MUL_W'(r_rm[RM_W-1:MUL_W]);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_comb begin
        case (r_prod_step)
            STEP_SIG_LO, STEP_NZ_LL: begin
                w_term = ACC_W'(r_prod);
            end
            STEP_SIG_HI, STEP_NZ_LH, STEP_NZ_HL: begin
                w_term = ACC_W'({r_prod, {MUL_W{1'b0}}});
            end
            STEP_NZ_HH: begin
                w_term = ACC_W'({r_prod, {(2*MUL_W){1'b0}}});
            end
            default: begin
                w_term = '0;
            end
        endcase
        n_acc = (r_prod_step >= STEP_NZ_LL) ? r_acc - w_term : r_acc + w_term;
    end

    // negative difference means signal*n*256 < noise*ratio*m
    assign w_snr_low = r_zero ? (i_cfg.snr_ratio_min > RATIO_ONE) : r_acc[ACC_W-1];

    always_comb begin
        if (r_rec.peak < i_cfg.silence_floor) begin
            w_quality = Q_SILENT;
        end else if (r_rec.clip != '0) begin
            w_quality = Q_CLIPPING;
        end else if (r_rec.peak < i_cfg.good_peak_min) begin
            w_quality = Q_LEVEL_LOW;
        end else if (w_snr_low) begin
            w_quality = Q_LOW_SNR;
        end else begin
            w_quality = Q_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_step       <= '0;
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prod_valid <= (r_state == B_MUL);
            if (o_pop) begin
                r_step <= '0;
            end else if (r_state == B_MUL) begin
                r_step <= r_step + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= w_a * w_b;
        r_prod_step <= r_step;
        if (o_pop) begin
            r_rec  <= i_rec;
            r_n    <= w_n;
            r_m    <= w_m;
            r_zero <= (w_n == '0) || (w_m == '0) ||
                      (i_rec.noise_sum == '0) || (i_rec.signal_sum == '0);
            r_acc  <= '0;
        end else if (r_prod_valid && r_prod_step != STEP_RM) begin
            r_acc <= n_acc;
        end
        if (r_prod_valid && r_prod_step == STEP_RM) begin
            r_rm <= r_prod[RM_W-1:0];
        end
        if (w_load_out) begin
            r_out_peak    <= r_rec.peak;
            r_out_clip    <= r_rec.clip;
            r_out_quality <= w_quality;
            r_out_total   <= r_rec.total;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_peak_level    = r_out_peak;
    assign o_clipped_count = r_out_clip;
    assign o_quality       = r_out_quality;
    assign o_sample_total  = r_out_total;

    a_drain_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DRAIN) |=> (r_state == B_DONE))
        else $error("back end left drain without finishing");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == B_DONE))
        else $error("result word raised outside done state");

endmodule

### src/capture_level_quality_check.sv
`timescale 1ns / 1ps
// top level of the capture level quality check with its configuration registers
// throughput: one sample word per cycle, held off while a finished capture waits
// on a full summary queue; the front end squares and accumulates in two stages
// the back end runs the 32x32 multiplier sequence for the snr test on each capture
// a two-entry summary queue lets the front end run on while the back end evaluates
// reset: synchronous active low, clears all sums, counters and queues, loads register defaults
module capture_level_quality_check (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wr_en,
    input  logic [clqc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [clqc_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [clqc_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                                    i_last,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [clqc_pkg::SAMPLE_W-1:0]           o_peak_level,
    output logic [clqc_pkg::CNT_W-1:0]              o_clipped_count,
    output logic [2:0]                              o_quality,
    output logic [clqc_pkg::CNT_W-1:0]              o_sample_total
);
    import clqc_pkg::*;

    t_cfg     r_cfg;
    logic     w_push;
    logic     w_push_ready;
    t_summary w_push_data;
    logic     w_rec_valid;
    logic     w_pop;
    t_summary w_rec;
    t_quality w_quality;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_threshold <= RST_CLIP_THRESHOLD;
            r_cfg.silence_floor  <= RST_SILENCE_FLOOR;
            r_cfg.good_peak_min  <= RST_GOOD_PEAK_MIN;
            r_cfg.snr_ratio_min  <= RST_SNR_RATIO_MIN;
            r_cfg.pre_count      <= RST_PRE_COUNT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CLIP_THRESHOLD: r_cfg.clip_threshold <= i_cfg_data[SAMPLE_W-1:0];
                CFG_SILENCE_FLOOR:  r_cfg.silence_floor  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_GOOD_PEAK_MIN:  r_cfg.good_peak_min  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_SNR_RATIO_MIN:  r_cfg.snr_ratio_min  <= i_cfg_data[RATIO_W-1:0];
                CFG_PRE_COUNT:      r_cfg.pre_count      <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    clqc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_sample     (i_sample),
        .i_last       (i_last),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_summary    (w_push_data)
    );

    clqc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_push_ready),
        .i_data  (w_push_data),
        .o_valid (w_rec_valid),
        .i_pop   (w_pop),
        .o_data  (w_rec)
    );

    clqc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_rec_valid     (w_rec_valid),
        .o_pop           (w_pop),
        .i_rec           (w_rec),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_peak_level    (o_peak_level),
        .o_clipped_count (o_clipped_count),
        .o_quality       (w_quality),
        .o_sample_total  (o_sample_total)
    );

    assign o_quality = w_quality;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the capture level quality check with a built-in capture scorer
module testbench;
    import clqc_pkg::*;

    localparam int     FULL_SCALE    = 1 << (SAMPLE_W - 1);
    localparam int     SETTLE_CYCLES = 40;
    localparam int     LONG_STALL    = 400;
    localparam int     MAX_REPORTED  = 10;
    localparam int     QUEUE_LIMIT   = 8;
    localparam longint TIMEOUT_NS    = 60_000_000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       tail;
    } t_word;

    typedef struct packed {
        logic [SAMPLE_W-1:0] peak;
        logic [CNT_W-1:0]    clipped;
        t_quality            quality;
        logic [CNT_W-1:0]    total;
    } t_report;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_last = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [SAMPLE_W-1:0]        o_peak_level;
    logic [CNT_W-1:0]           o_clipped_count;
    logic [2:0]                 o_quality;
    logic [CNT_W-1:0]           o_sample_total;

    t_word   pending_words[$];
    t_report expected_reports[$];
    int      mismatches = 0;
    int      send_gap_pct = 10;
    int      recv_gap_pct = 58;
    logic    stall_go = 1'b0;
    int      stall_left = 0;

    // register copies
    logic [SAMPLE_W-1:0] thr_clip;
    logic [SAMPLE_W-1:0] thr_silent;
    logic [SAMPLE_W-1:0] thr_level;
    logic [RATIO_W-1:0]  snr_floor;
    logic [CNT_W-1:0]    noise_len;

    // running capture statistics
    logic [SAMPLE_W-1:0] held_peak;
    logic [CNT_W-1:0]    clip_tally;
    logic [SUM_W-1:0]    noise_energy;
    logic [SUM_W-1:0]    signal_energy;
    logic [CNT_W-1:0]    word_tally;

    capture_level_quality_check u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample        (i_sample),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_peak_level    (o_peak_level),
        .o_clipped_count (o_clipped_count),
        .o_quality       (o_quality),
        .o_sample_total  (o_sample_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic void clear_capture();
        held_peak     = '0;
        clip_tally    = '0;
        noise_energy  = '0;
        signal_energy = '0;
        word_tally    = '0;
    endfunction

    function automatic void reset_scorer();
        thr_clip   = RST_CLIP_THRESHOLD;
        thr_silent = RST_SILENCE_FLOOR;
        thr_level  = RST_GOOD_PEAK_MIN;
        snr_floor  = RST_SNR_RATIO_MIN;
        noise_len  = RST_PRE_COUNT;
        clear_capture();
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_CLIP_THRESHOLD: thr_clip = value[SAMPLE_W-1:0];
            CFG_SILENCE_FLOOR:  thr_silent = value[SAMPLE_W-1:0];
            CFG_GOOD_PEAK_MIN:  thr_level = value[SAMPLE_W-1:0];
            CFG_SNR_RATIO_MIN:  snr_floor = value[RATIO_W-1:0];
            CFG_PRE_COUNT:      noise_len = value[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = a + b;
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    // mean power compare by cross-multiplication
    function automatic logic snr_below_floor();
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] m;
        logic [127:0]     lhs;
        logic [127:0]     rhs;
        n = (noise_len < word_tally) ? noise_len : word_tally;
        m = word_tally - n;
        if (n == 0 || m == 0 || noise_energy == 0 || signal_energy == 0) begin
            return snr_floor > RATIO_ONE;
        end
        lhs = 128'(signal_energy) * 128'({n, 8'd0});
        rhs = 128'(noise_energy) * 128'(snr_floor) * 128'(m);
        return lhs < rhs;
    endfunction

    function automatic void capture_step(input logic signed [SAMPLE_W-1:0] smp,
                                         input logic tail);
        logic [SAMPLE_W-1:0] mag;
        logic [SUM_W-1:0]    sq;
        t_report             rep;
        mag = smp[SAMPLE_W-1] ? (~smp + 1'b1) : smp;
        sq  = mag * mag;
        if (mag > held_peak) begin
            held_peak = mag;
        end
        if (mag >= thr_clip && clip_tally < COUNT_CAP) begin
            clip_tally = clip_tally + 1'b1;
        end
        if (word_tally < noise_len) begin
            noise_energy = sat_sum(noise_energy, sq);
        end else begin
            signal_energy = sat_sum(signal_energy, sq);
        end
        if (word_tally < COUNT_CAP) begin
            word_tally = word_tally + 1'b1;
        end
        if (tail) begin
            if (held_peak < thr_silent) begin
                rep.quality = Q_SILENT;
            end else if (clip_tally != 0) begin
                rep.quality = Q_CLIPPING;
            end else if (held_peak < thr_level) begin
                rep.quality = Q_LEVEL_LOW;
            end else if (snr_below_floor()) begin
                rep.quality = Q_LOW_SNR;
            end else begin
                rep.quality = Q_OK;
            end
            rep.peak    = held_peak;
            rep.clipped = clip_tally;
            rep.total   = word_tally;
            expected_reports.push_back(rep);
            clear_capture();
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    function automatic void check_report();
        t_report got;
        t_report want;
        got.peak    = o_peak_level;
        got.clipped = o_clipped_count;
        got.quality = t_quality'(o_quality);
        got.total   = o_sample_total;
        if (expected_reports.size() == 0) begin
            note_failure($sformatf("unexpected result: peak %0d clip %0d quality %0d total %0d",
                                   got.peak, got.clipped, got.quality, got.total));
            return;
        end
        want = expected_reports.pop_front();
        if (got.peak !== want.peak || got.clipped !== want.clipped ||
            got.quality !== want.quality || got.total !== want.total) begin
            note_failure($sformatf("exp/act peak %0d/%0d clip %0d/%0d quality %0d/%0d total %0d/%0d",
                                   want.peak, got.peak, want.clipped, got.clipped,
                                   want.quality, got.quality, want.total, got.total));
        end
    endfunction

    // sample word driver
    always @(posedge i_clk) begin
        if (i_rst_n && (!i_in_valid || o_in_ready)) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                i_sample   <= pending_words[0].smp;
                i_last     <= pending_words[0].tail;
                i_in_valid <= 1'b1;
                void'(pending_words.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result word acceptance
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_go) begin
            stall_left  <= LONG_STALL;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_scorer();
        end else begin
            if (i_cfg_wr_en) begin
                apply_register(i_cfg_index, i_cfg_data);
            end
            if (o_out_valid && i_out_ready) begin
                check_report();
            end
            if (i_in_valid && o_in_ready) begin
                capture_step(i_sample, i_last);
            end
        end
    end

    task automatic push_word(input logic signed [SAMPLE_W-1:0] smp, input logic tail);
        t_word w;
        while (pending_words.size() >= QUEUE_LIMIT) begin
            @(negedge i_clk);
        end
        w.smp  = smp;
        w.tail = tail;
        pending_words.push_back(w);
    endtask

    task automatic wait_idle(input int settle);
        do begin
            @(negedge i_clk);
        end while (pending_words.size() != 0 || i_in_valid || expected_reports.size() != 0);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
    endtask

    task automatic cfg_end();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_reg(input logic [CFG_IDX_W-1:0] idx);
        int unsigned           r;
        logic [CFG_DATA_W-1:0] v;
        r = $urandom_range(7);
        case (idx)
            CFG_CLIP_THRESHOLD:
                v = (r == 0) ? 0 : (r == 1) ? FULL_SCALE : $urandom_range(FULL_SCALE, 4000000);
            CFG_SILENCE_FLOOR:
                v = (r == 0) ? 0 : (r == 1) ? FULL_SCALE : $urandom_range(20000, 1);
            CFG_GOOD_PEAK_MIN:
                v = (r == 0) ? 0 : (r == 1) ? FULL_SCALE : $urandom_range(2000000, 20000);
            CFG_SNR_RATIO_MIN:
                v = (r == 0) ? 0 : (r == 1) ? RATIO_ONE : (r == 2) ? RATIO_ONE + 1 :
                    (r == 3) ? 32'hFFFF_FFFF : $urandom_range(300000, 1);
            CFG_PRE_COUNT: begin
                v = (r == 0) ? 0 : (r == 1) ? 32'hFFFF_FFFF : $urandom_range(16, 1);
                if (r != 1) begin
                    v[CFG_DATA_W-1:CNT_W] = (CFG_DATA_W-CNT_W)'($urandom);
                end
            end
            default: v = $urandom;
        endcase
        if (idx == CFG_CLIP_THRESHOLD || idx == CFG_SILENCE_FLOOR ||
            idx == CFG_GOOD_PEAK_MIN) begin
            v[CFG_DATA_W-1:SAMPLE_W] = (CFG_DATA_W-SAMPLE_W)'($urandom);
        end
        return v;
    endfunction

    task automatic random_config();
        for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
            cfg_write(CFG_IDX_W'(i), rand_reg(CFG_IDX_W'(i)));
        end
        cfg_end();
    endtask

    // amplitude drawn around the current level thresholds
    function automatic int unsigned level_amp();
        case ($urandom_range(5))
            0:       return $urandom_range(thr_silent, 0);
            1:       return $urandom_range(thr_level, thr_silent);
            2, 3:    return $urandom_range(thr_clip, thr_level);
            4:       return $urandom_range(FULL_SCALE, thr_clip);
            default: return FULL_SCALE;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int unsigned amp);
        int unsigned mag;
        int          value;
        mag = ($urandom_range(3) == 0) ? amp : $urandom_range(amp, 0);
        if (mag > FULL_SCALE) begin
            mag = FULL_SCALE;
        end
        value = (mag == FULL_SCALE || $urandom_range(1)) ? -int'(mag) : int'(mag);
        return value[SAMPLE_W-1:0];
    endfunction

    task automatic push_capture(input int unsigned len);
        int unsigned noise_amp;
        int unsigned signal_amp;
        logic        raw;
        noise_amp  = level_amp();
        signal_amp = level_amp();
        raw        = ($urandom_range(9) == 0);
        for (int unsigned k = 0; k < len; k++) begin
            push_word(raw ? SAMPLE_W'($urandom) :
                      rand_sample((k < noise_len) ? noise_amp : signal_amp), k == len - 1);
        end
    endtask

    task automatic random_block(input int n);
        int          sent;
        int unsigned len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(60, 20);
            end else if (noise_len <= 16 && $urandom_range(1)) begin
                len = noise_len + $urandom_range(6, 1);
            end else begin
                len = $urandom_range(10, 1);
            end
            push_capture(len);
            sent += len;
        end
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct);
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        for (int b = 0; b < 3; b++) begin
            random_block(90);
            wait_idle(SETTLE_CYCLES);
            random_config();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults after reset
        push_word(SAMPLE_W'(-FULL_SCALE), 1'b1);
        push_word(SAMPLE_W'(0), 1'b1);
        push_word(SAMPLE_W'(FULL_SCALE - 1), 1'b1);
        push_word(SAMPLE_W'(1000000), 1'b0);
        push_word(SAMPLE_W'(-1000000), 1'b0);
        push_word(SAMPLE_W'(500), 1'b1);
        push_word(SAMPLE_W'(-1), 1'b1);
        wait_idle(SETTLE_CYCLES);

        // wide values, zero silence and level thresholds, two noise words
        cfg_write(CFG_CLIP_THRESHOLD, 32'hFF80_0000);
        cfg_write(CFG_SILENCE_FLOOR, 32'hFF00_0000);
        cfg_write(CFG_GOOD_PEAK_MIN, 32'h0100_0000);
        cfg_write(CFG_SNR_RATIO_MIN, RATIO_ONE);
        cfg_write(CFG_PRE_COUNT, 32'hFFE0_0002);
        cfg_end();
        push_word(SAMPLE_W'(100), 1'b0);
        push_word(SAMPLE_W'(100), 1'b0);
        push_word(SAMPLE_W'(400), 1'b0);
        push_word(SAMPLE_W'(400), 1'b1);
        push_word(SAMPLE_W'(0), 1'b0);
        push_word(SAMPLE_W'(0), 1'b0);
        push_word(SAMPLE_W'(5), 1'b0);
        push_word(SAMPLE_W'(5), 1'b1);
        push_word(SAMPLE_W'(3), 1'b1);
        push_word(SAMPLE_W'(-FULL_SCALE), 1'b1);
        wait_idle(SETTLE_CYCLES);

        // zero noise power against a ratio just above unity
        cfg_write(CFG_SNR_RATIO_MIN, RATIO_ONE + 1);
        cfg_end();
        push_word(SAMPLE_W'(0), 1'b0);
        push_word(SAMPLE_W'(0), 1'b0);
        push_word(SAMPLE_W'(5), 1'b0);
        push_word(SAMPLE_W'(5), 1'b1);
        wait_idle(SETTLE_CYCLES);

        cfg_write(CFG_SNR_RATIO_MIN, 32'hFFFF_FFFF);
        cfg_write(CFG_PRE_COUNT, 1);
        cfg_end();
        push_word(SAMPLE_W'(7), 1'b0);
        push_word(SAMPLE_W'(FULL_SCALE - 1), 1'b1);
        wait_idle(SETTLE_CYCLES);
        random_config();

        random_phase(10, 58);
        random_phase(58, 10);
        random_phase(0, 0);

        // receiver holds off while short captures pile up
        @(posedge i_clk);
        stall_go <= 1'b1;
        @(posedge i_clk);
        stall_go <= 1'b0;
        @(negedge i_clk);
        for (int c = 0; c < 24; c++) begin
            push_capture($urandom_range(3, 1));
        end

        wait_idle(SETTLE_CYCLES);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
src/clqc_pkg.sv
src/clqc_front.sv
src/clqc_queue.sv
src/clqc_back.sv
src/capture_level_quality_check.sv
bench/testbench.sv
